@@ rtl/scs1a_pkg.sv @@
// scs1a_pkg: shared types, scan codes and key map for the set-1 scan-code decoder
// no dependencies; imported by scancode_set1_to_ascii and tb_scancode_set1_to_ascii
`default_nettype none

package scs1a_pkg;

  localparam logic [7:0] ScanPrefix = 8'hE0;  // extended-key prefix byte
  localparam int unsigned BreakBit = 7;       // set on key release

  localparam logic [6:0] KeyLast   = 7'h3A;
  localparam logic [6:0] KeyCtrl   = 7'h1D;
  localparam logic [6:0] KeyLShift = 7'h2A;
  localparam logic [6:0] KeyRShift = 7'h36;
  localparam logic [6:0] KeyAlt    = 7'h38;
  localparam logic [6:0] KeyCaps   = 7'h3A;

  typedef struct packed {
    logic [6:0] shifted;
    logic [6:0] plain;
  } key_pair_t;

  // keys whose second column follows shift alone, caps lock has no effect
  function automatic logic shift_only_key(input logic [6:0] code);
    logic res;
    case (code) inside
      [7'h00:7'h0D], 7'h1A, 7'h1B, 7'h27, 7'h28, 7'h29, 7'h2B,
      7'h33, 7'h34, 7'h35: res = 1'b1;
      default:             res = 1'b0;
    endcase
    return res;
  endfunction

  // ascii map, zero marks a modifier or an unused code
  function automatic key_pair_t key_map(input logic [5:0] idx);
    key_pair_t res;
    unique case (idx)
      6'h01: res = '{7'h1B, 7'h1B};
      6'h02: res = '{7'h21, 7'h31};
      6'h03: res = '{7'h40, 7'h32};
      6'h04: res = '{7'h23, 7'h33};
      6'h05: res = '{7'h24, 7'h34};
      6'h06: res = '{7'h25, 7'h35};
      6'h07: res = '{7'h5E, 7'h36};
      6'h08: res = '{7'h26, 7'h37};
      6'h09: res = '{7'h2A, 7'h38};
      6'h0A: res = '{7'h28, 7'h39};
      6'h0B: res = '{7'h29, 7'h30};
      6'h0C: res = '{7'h5F, 7'h2D};
      6'h0D: res = '{7'h2B, 7'h3D};
      6'h0E: res = '{7'h08, 7'h08};
      6'h0F: res = '{7'h09, 7'h09};
      6'h10: res = '{7'h51, 7'h71};
      6'h11: res = '{7'h57, 7'h77};
      6'h12: res = '{7'h45, 7'h65};
      6'h13: res = '{7'h52, 7'h72};
      6'h14: res = '{7'h54, 7'h74};
      6'h15: res = '{7'h59, 7'h79};
      6'h16: res = '{7'h55, 7'h75};
      6'h17: res = '{7'h49, 7'h69};
      6'h18: res = '{7'h4F, 7'h6F};
      6'h19: res = '{7'h50, 7'h70};
      6'h1A: res = '{7'h7B, 7'h5B};
      6'h1B: res = '{7'h7D, 7'h5D};
      6'h1C: res = '{7'h0D, 7'h0D};
      6'h1E: res = '{7'h41, 7'h61};
      6'h1F: res = '{7'h53, 7'h73};
      6'h20: res = '{7'h44, 7'h64};
      6'h21: res = '{7'h46, 7'h66};
      6'h22: res = '{7'h47, 7'h67};
      6'h23: res = '{7'h48, 7'h68};
      6'h24: res = '{7'h4A, 7'h6A};
      6'h25: res = '{7'h4B, 7'h6B};
      6'h26: res = '{7'h4C, 7'h6C};
      6'h27: res = '{7'h3A, 7'h3B};
      6'h28: res = '{7'h22, 7'h27};
      6'h29: res = '{7'h7E, 7'h60};
      6'h2B: res = '{7'h7C, 7'h5C};
      6'h2C: res = '{7'h5A, 7'h7A};
      6'h2D: res = '{7'h58, 7'h78};
      6'h2E: res = '{7'h43, 7'h63};
      6'h2F: res = '{7'h56, 7'h76};
      6'h30: res = '{7'h42, 7'h62};
      6'h31: res = '{7'h4E, 7'h6E};
      6'h32: res = '{7'h4D, 7'h6D};
      6'h33: res = '{7'h3C, 7'h2C};
      6'h34: res = '{7'h3E, 7'h2E};
      6'h35: res = '{7'h3F, 7'h2F};
      6'h37: res = '{7'h2A, 7'h2A};
      6'h39: res = '{7'h20, 7'h20};
      default: res = '{7'h00, 7'h00};
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/scancode_set1_to_ascii.sv @@
// scancode_set1_to_ascii: set-1 keyboard scan-code to ascii decoder, top level
// depends on scs1a_pkg for scan codes and the key map
`default_nettype none

// usage
// - input channel (in_valid / in_ready): one raw scan-code byte per word, with
//   in_buffer_full telling whether the downstream character buffer is full
// - result channel (out_valid / out_ready): exactly one word per input byte,
//   carrying the decoded character (or none), an unknown-key flag and the
//   ctrl, shift, alt and caps-lock states after that byte
// - two register stages: an input register, then the decode and modifier
//   update, then the result register; an accepted byte waits in the input
//   register until the result register is free, then out_valid rises
// - throughput is one byte per cycle while out_ready stays high; the key map
//   lookup and flag update between the two registers are combinational
// - 0xE0 arms a prefix flag that applies to the next byte only; its own
//   result word carries no character and no unknown flag
// - when out_ready is low the result register holds its word, the input
//   register fills, and in_ready drops only once both are occupied
// - modifier state changes when a byte moves from the input register into
//   the result register, so results always follow byte order
// - reset (rst_n low, synchronous) empties both stages and clears the
//   prefix flag and all modifier states
module scancode_set1_to_ascii (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_scan_byte,
  input  wire logic       in_buffer_full,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_char_valid,
  output logic [6:0]      out_ascii_char,
  output logic            out_unknown_key,
  output logic            out_ctrl_down,
  output logic            out_shift_down,
  output logic            out_alt_down,
  output logic            out_caps_on
);
  import scs1a_pkg::*;

  // input stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_full_r;

  // keyboard state
  logic prefix_r, prefix_nxt;
  logic ctrl_r, ctrl_nxt;
  logic shift_r, shift_nxt;
  logic alt_r, alt_nxt;
  logic caps_r, caps_nxt;

  // result stage
  logic       out_valid_r, out_valid_nxt;
  logic       char_valid_r, char_valid_nxt;
  logic [6:0] ascii_r, ascii_nxt;
  logic       unknown_r, unknown_nxt;

  logic       s2_free;
  logic       advance;
  logic       in_take;
  logic [6:0] code;
  logic       handled;
  logic       col_sel;
  key_pair_t  pair;
  logic [6:0] ch;

  assign s2_free  = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;
  assign in_take  = in_valid && in_ready;

  assign code = s1_byte_r[6:0];

  // make codes that go through the key map; extended ones are right ctrl and alt
  assign handled = prefix_r ? (code == KeyCtrl || code == KeyAlt)
                            : (code != 7'h00 && code <= KeyLast);

  assign col_sel = (!prefix_r && shift_only_key(code)) ? shift_r : (shift_r ^ caps_r);
  assign pair    = key_map(code[5:0]);
  assign ch      = col_sel ? pair.shifted : pair.plain;

  always_comb begin
    prefix_nxt     = prefix_r;
    ctrl_nxt       = ctrl_r;
    shift_nxt      = shift_r;
    alt_nxt        = alt_r;
    caps_nxt       = caps_r;
    char_valid_nxt = 1'b0;
    ascii_nxt      = '0;
    unknown_nxt    = 1'b0;
    if (s1_byte_r == ScanPrefix) begin
      prefix_nxt = 1'b1;
    end else begin
      prefix_nxt = 1'b0;
      if (s1_byte_r[BreakBit]) begin
        // release: extended shift codes leave shift alone
        if (code == KeyCtrl) begin
          ctrl_nxt = 1'b0;
        end else if (!prefix_r && (code == KeyLShift || code == KeyRShift)) begin
          shift_nxt = 1'b0;
        end else if (code == KeyAlt) begin
          alt_nxt = 1'b0;
        end
      end else if (handled) begin
        if (ch != 7'h00) begin
          if (!s1_full_r) begin
            char_valid_nxt = 1'b1;
            ascii_nxt      = ch;
          end
        end else if (code == KeyCtrl) begin
          ctrl_nxt = 1'b1;
        end else if (code == KeyLShift || code == KeyRShift) begin
          shift_nxt = 1'b1;
        end else if (code == KeyAlt) begin
          alt_nxt = 1'b1;
        end else if (code == KeyCaps) begin
          caps_nxt = !caps_r;
        end
      end else begin
        unknown_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prefix_r    <= 1'b0;
      ctrl_r      <= 1'b0;
      shift_r     <= 1'b0;
      alt_r       <= 1'b0;
      caps_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        prefix_r <= prefix_nxt;
        ctrl_r   <= ctrl_nxt;
        shift_r  <= shift_nxt;
        alt_r    <= alt_nxt;
        caps_r   <= caps_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_scan_byte;
      s1_full_r <= in_buffer_full;
    end
    if (advance) begin
      char_valid_r <= char_valid_nxt;
      ascii_r      <= ascii_nxt;
      unknown_r    <= unknown_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_valid  = char_valid_r;
  assign out_ascii_char  = ascii_r;
  assign out_unknown_key = unknown_r;
  // state registers load together with the result word, so they match it
  assign out_ctrl_down   = ctrl_r;
  assign out_shift_down  = shift_r;
  assign out_alt_down    = alt_r;
  assign out_caps_on     = caps_r;

endmodule

`default_nettype wire

@@ rtl/scs1a_checker.sv @@
// scs1a_checker: port-level checks on the scan-code decoder, bound to the top level
// depends on scancode_set1_to_ascii ports only
`default_nettype none

module scs1a_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_char_valid,
  input wire logic [6:0] out_ascii_char,
  input wire logic       out_unknown_key,
  input wire logic       out_ctrl_down,
  input wire logic       out_shift_down,
  input wire logic       out_alt_down,
  input wire logic       out_caps_on
);

  // stalled result word holds, modifier states included
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_valid) &&
      $stable(out_ascii_char) && $stable(out_unknown_key) && $stable(out_ctrl_down) &&
      $stable(out_shift_down) && $stable(out_alt_down) && $stable(out_caps_on))
    else $error("result word changed while stalled");

  // no character means a zero code
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_ascii_char == 7'h00)
    else $error("character code without char_valid");

  // a delivered character is never zero and never an unknown key
  a_char_real: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_valid |-> out_ascii_char != 7'h00 && !out_unknown_key)
    else $error("bad character word");

  // with both stages stalled and full, the input side must back off
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && in_valid && !in_ready |=> !in_ready || out_ready ||
      !out_valid)
    else $error("input accepted while both stages full");

endmodule

bind scancode_set1_to_ascii scs1a_checker u_scs1a_checker (.*);

`default_nettype wire

@@ sim/tb_scancode_set1_to_ascii.sv @@
// tb_scancode_set1_to_ascii: self-checking bench for the set-1 scan-code decoder
// runs directed and random byte streams through valid/ready on both sides
// depends on scs1a_pkg and scancode_set1_to_ascii from rtl
`timescale 1ns / 100ps

module tb_scancode_set1_to_ascii;
  import scs1a_pkg::*;

  // one result word as the decoder should present it
  typedef struct packed {
    logic       char_valid;
    logic [6:0] ascii_char;
    logic       unknown_key;
    logic       ctrl_down;
    logic       shift_down;
    logic       alt_down;
    logic       caps_on;
  } decode_word_t;

  class decode_scoreboard;
    // mirrored decoder state
    logic prefix_armed;
    logic ctrl_held;
    logic shift_held;
    logic alt_held;
    logic caps_latched;

    decode_word_t pending_words[$];
    int unsigned  fails;

    function new();
      prefix_armed = 1'b0;
      ctrl_held    = 1'b0;
      shift_held   = 1'b0;
      alt_held     = 1'b0;
      caps_latched = 1'b0;
      fails        = 0;
    endfunction

    // digits and punctuation, caps lock has no say on these
    function logic follows_shift_only(logic [6:0] key);
      case (key) inside
        7'h1A, 7'h1B, 7'h27, 7'h28, 7'h29, 7'h2B, 7'h33, 7'h34, 7'h35: return 1'b1;
        default: return key < 7'h0E;
      endcase
    endfunction

    // {shifted, plain} character for a make code, zero for modifiers
    function logic [13:0] key_chars(logic [5:0] idx);
      case (idx)
        6'h01: return {7'h1B, 7'h1B};  6'h02: return {7'h21, 7'h31};
        6'h03: return {7'h40, 7'h32};  6'h04: return {7'h23, 7'h33};
        6'h05: return {7'h24, 7'h34};  6'h06: return {7'h25, 7'h35};
        6'h07: return {7'h5E, 7'h36};  6'h08: return {7'h26, 7'h37};
        6'h09: return {7'h2A, 7'h38};  6'h0A: return {7'h28, 7'h39};
        6'h0B: return {7'h29, 7'h30};  6'h0C: return {7'h5F, 7'h2D};
        6'h0D: return {7'h2B, 7'h3D};  6'h0E: return {7'h08, 7'h08};
        6'h0F: return {7'h09, 7'h09};  6'h10: return {7'h51, 7'h71};
        6'h11: return {7'h57, 7'h77};  6'h12: return {7'h45, 7'h65};
        6'h13: return {7'h52, 7'h72};  6'h14: return {7'h54, 7'h74};
        6'h15: return {7'h59, 7'h79};  6'h16: return {7'h55, 7'h75};
        6'h17: return {7'h49, 7'h69};  6'h18: return {7'h4F, 7'h6F};
        6'h19: return {7'h50, 7'h70};  6'h1A: return {7'h7B, 7'h5B};
        6'h1B: return {7'h7D, 7'h5D};  6'h1C: return {7'h0D, 7'h0D};
        6'h1E: return {7'h41, 7'h61};  6'h1F: return {7'h53, 7'h73};
        6'h20: return {7'h44, 7'h64};  6'h21: return {7'h46, 7'h66};
        6'h22: return {7'h47, 7'h67};  6'h23: return {7'h48, 7'h68};
        6'h24: return {7'h4A, 7'h6A};  6'h25: return {7'h4B, 7'h6B};
        6'h26: return {7'h4C, 7'h6C};  6'h27: return {7'h3A, 7'h3B};
        6'h28: return {7'h22, 7'h27};  6'h29: return {7'h7E, 7'h60};
        6'h2B: return {7'h7C, 7'h5C};  6'h2C: return {7'h5A, 7'h7A};
        6'h2D: return {7'h58, 7'h78};  6'h2E: return {7'h43, 7'h63};
        6'h2F: return {7'h56, 7'h76};  6'h30: return {7'h42, 7'h62};
        6'h31: return {7'h4E, 7'h6E};  6'h32: return {7'h4D, 7'h6D};
        6'h33: return {7'h3C, 7'h2C};  6'h34: return {7'h3E, 7'h2E};
        6'h35: return {7'h3F, 7'h2F};  6'h37: return {7'h2A, 7'h2A};
        6'h39: return {7'h20, 7'h20};
        default: return 14'h0;
      endcase
    endfunction

    // decode one accepted byte, update the mirror and queue the expected word
    function void note_byte(logic [7:0] scan, logic full);
      decode_word_t want;
      logic         was_prefixed;
      logic [6:0]   key;
      logic         upper;
      logic [13:0]  pair;
      logic [6:0]   ch;
      want = '0;
      if (scan == ScanPrefix) begin
        prefix_armed = 1'b1;
      end else begin
        was_prefixed = prefix_armed;
        prefix_armed = 1'b0;
        key = scan[6:0];
        if (scan[BreakBit]) begin
          if (key == KeyCtrl) begin
            ctrl_held = 1'b0;
          end else if (!was_prefixed && (key == KeyLShift || key == KeyRShift)) begin
            shift_held = 1'b0;
          end else if (key == KeyAlt) begin
            alt_held = 1'b0;
          end
        end else if (was_prefixed ? (key == KeyCtrl || key == KeyAlt)
                                  : (key != 7'h00 && key <= KeyLast)) begin
          upper = (!was_prefixed && follows_shift_only(key)) ? shift_held
                                                             : shift_held ^ caps_latched;
          pair = key_chars(key[5:0]);
          ch = upper ? pair[13:7] : pair[6:0];
          if (ch != 7'h00) begin
            if (!full) begin
              want.char_valid = 1'b1;
              want.ascii_char = ch;
            end
          end else if (key == KeyCtrl) begin
            ctrl_held = 1'b1;
          end else if (key == KeyLShift || key == KeyRShift) begin
            shift_held = 1'b1;
          end else if (key == KeyAlt) begin
            alt_held = 1'b1;
          end else if (key == KeyCaps) begin
            caps_latched = ~caps_latched;
          end
        end else begin
          want.unknown_key = 1'b1;
        end
      end
      want.ctrl_down  = ctrl_held;
      want.shift_down = shift_held;
      want.alt_down   = alt_held;
      want.caps_on    = caps_latched;
      pending_words.push_back(want);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        fails++;
      end
    endfunction

    function void check_word(decode_word_t got);
      decode_word_t want;
      if (pending_words.size() == 0) begin
        $error("result word with no byte waiting for it");
        fails++;
        return;
      end
      want = pending_words.pop_front();
      compare_field("char_valid",  32'(want.char_valid),  32'(got.char_valid));
      compare_field("ascii_char",  32'(want.ascii_char),  32'(got.ascii_char));
      compare_field("unknown_key", 32'(want.unknown_key), 32'(got.unknown_key));
      compare_field("ctrl_down",   32'(want.ctrl_down),   32'(got.ctrl_down));
      compare_field("shift_down",  32'(want.shift_down),  32'(got.shift_down));
      compare_field("alt_down",    32'(want.alt_down),    32'(got.alt_down));
      compare_field("caps_on",     32'(want.caps_on),     32'(got.caps_on));
    endfunction
  endclass

  localparam int unsigned StallLimit = 1000;  // cycles with no word moving
  localparam int unsigned PhaseBytes = 170;   // random bytes per idling phase

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_scan_byte = 8'h00;
  logic       in_buffer_full = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_char_valid;
  logic [6:0] out_ascii_char;
  logic       out_unknown_key;
  logic       out_ctrl_down;
  logic       out_shift_down;
  logic       out_alt_down;
  logic       out_caps_on;

  // idle odds in percent, changed per phase
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 76;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  decode_scoreboard sb = new();

  scancode_set1_to_ascii u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_scan_byte    (in_scan_byte),
    .in_buffer_full  (in_buffer_full),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_valid  (out_char_valid),
    .out_ascii_char  (out_ascii_char),
    .out_unknown_key (out_unknown_key),
    .out_ctrl_down   (out_ctrl_down),
    .out_shift_down  (out_shift_down),
    .out_alt_down    (out_alt_down),
    .out_caps_on     (out_caps_on)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: random back-pressure, and both handshakes sampled at the edge.
  // a result word is checked before the same edge's input word is noted, though
  // the two can never pair up since the decoder has two register stages
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_word({out_char_valid, out_ascii_char, out_unknown_key,
                       out_ctrl_down, out_shift_down, out_alt_down, out_caps_on});
      end
      if (in_valid && in_ready) begin
        sb.note_byte(in_scan_byte, in_buffer_full);
      end
    end
  end

  // watchdog: a run of cycles in which no word moves on either side means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // present one byte and hold it until the decoder takes it; on return we sit
  // in the step of acceptance, so the next call drives in_valid only once
  task automatic send_byte(input logic [7:0] scan, input logic full);
    int unsigned gaps;
    gaps = 0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      gaps++;
    end
    if (gaps != 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_scan_byte   <= scan;
    in_buffer_full <= full;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // hold off the sender until every outstanding result word has come back
  task automatic drain_pending();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_words.size() != 0);
  endtask

  function automatic logic random_full();
    return $urandom_range(0, 99) < 15;
  endfunction

  // press and release an ordinary key from the handled range
  task automatic tap_key();
    logic [7:0] key;
    key = 8'($urandom_range(1, int'(KeyLast)));
    send_byte(key, random_full());
    send_byte({1'b1, key[6:0]}, random_full());
  endtask

  // one random chunk of keyboard traffic; mostly well-formed key sequences,
  // the rest broken prefixes, codes outside the table and plain noise
  task automatic keyboard_burst();
    int unsigned pick;
    int unsigned taps;
    logic [6:0]  modifier;
    logic        right_side;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      tap_key();
    end else if (pick < 60) begin
      // hold a modifier over a few keys, sometimes left held on purpose
      case ($urandom_range(0, 3))
        0:       modifier = KeyCtrl;
        1:       modifier = KeyLShift;
        2:       modifier = KeyRShift;
        default: modifier = KeyAlt;
      endcase
      right_side = (modifier == KeyCtrl || modifier == KeyAlt) && $urandom_range(0, 1);
      if (right_side) send_byte(ScanPrefix, random_full());
      send_byte({1'b0, modifier}, random_full());
      taps = $urandom_range(1, 4);
      repeat (taps) tap_key();
      if ($urandom_range(0, 99) < 80) begin
        if (right_side) send_byte(ScanPrefix, random_full());
        send_byte({1'b1, modifier}, random_full());
      end
    end else if (pick < 68) begin
      send_byte({1'b0, KeyCaps}, random_full());
      send_byte({1'b1, KeyCaps}, random_full());
    end else if (pick < 78) begin
      // prefix followed by anything, a second prefix included
      send_byte(ScanPrefix, random_full());
      send_byte(8'($urandom_range(0, 255)), random_full());
    end else if (pick < 86) begin
      // make codes outside the table
      if ($urandom_range(0, 7) == 0) begin
        send_byte(8'h00, random_full());
      end else begin
        send_byte(8'($urandom_range(int'(KeyLast) + 1, 8'h7F)), random_full());
      end
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned target;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening, run under the first idling mix
    send_byte(8'h01, 1'b0);                      // escape, same in both columns
    send_byte({1'b0, KeyLShift}, 1'b0);
    send_byte(8'h02, 1'b0);                      // shifted digit
    send_byte(8'h10, 1'b0);                      // shifted letter
    send_byte(ScanPrefix, 1'b0);                 // prefixed shift release leaves shift held
    send_byte({1'b1, KeyLShift}, 1'b0);
    send_byte({1'b1, KeyRShift}, 1'b0);          // either shift release clears it
    send_byte({1'b0, KeyCaps}, 1'b1);            // caps toggles even with buffer full
    send_byte(8'h10, 1'b0);                      // letter under caps
    send_byte(8'h0C, 1'b0);                      // punctuation ignores caps
    send_byte({1'b0, KeyRShift}, 1'b0);
    send_byte(8'h1E, 1'b0);                      // shift and caps cancel on a letter
    send_byte(8'h27, 1'b0);                      // but not on punctuation
    send_byte({1'b1, KeyLShift}, 1'b0);
    send_byte({1'b0, KeyCaps}, 1'b0);
    send_byte(ScanPrefix, 1'b0);                 // right ctrl
    send_byte({1'b0, KeyCtrl}, 1'b0);
    send_byte(ScanPrefix, 1'b0);                 // doubled prefix, then right alt
    send_byte(ScanPrefix, 1'b0);
    send_byte({1'b0, KeyAlt}, 1'b0);
    send_byte({1'b1, KeyCtrl}, 1'b0);            // left release clears right ctrl
    send_byte(ScanPrefix, 1'b0);
    send_byte({1'b1, KeyAlt}, 1'b0);
    send_byte(ScanPrefix, 1'b0);                 // prefixed make outside the pair
    send_byte({1'b0, KeyLShift}, 1'b0);
    send_byte(8'h00, 1'b0);                      // codes outside the table
    send_byte(8'h7F, 1'b0);
    send_byte(8'h39, 1'b1);                      // space dropped, buffer full
    send_byte(8'h39, 1'b0);
    send_byte(8'hFF, 1'b1);                      // release of an unmapped code
    drain_pending();

    // random traffic in three idling mixes, the last with no idling at all
    target = bytes_sent;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      target += PhaseBytes;
      while (bytes_sent < target) begin
        keyboard_burst();
        if ($urandom_range(0, 99) < 3) drain_pending();
      end
      drain_pending();
    end

    // everything is back; let a few more cycles pass for stray words
    in_valid <= 1'b0;
    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.pending_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
